>>> rtl/wlgs_pkg.sv
// ---------------------------------------------------------------------------
// wlgs_pkg
// Shared widths, register indexes, status codes and defaults for the
// layered wrapping grid store.
// ---------------------------------------------------------------------------
`default_nettype none

package wlgs_pkg;

  localparam int MAX_SIDE_DEF   = 128;
  localparam int MAX_LAYERS_DEF = 4;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int COORD_W    = 16;
  localparam int LAYER_W    = 4;
  localparam int VAL_W      = 32;
  localparam int SIZE_W     = 8;
  localparam int LCNT_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // remainder unit: bits folded per cycle and cycles per coordinate
  localparam int MOD_STEP  = 8;
  localparam int MOD_CYC   = COORD_W / MOD_STEP;
  localparam int MOD_CNT_W = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TORUS       = 2'd3;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LAYER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_WRITE = 2'd2;

  // response value source
  typedef enum logic [1:0] {
    RSEL_ZERO,
    RSEL_ONES,
    RSEL_MEM
  } rsel_t;

endpackage

`default_nettype wire

>>> rtl/wrapping_layered_grid_store.sv
// ---------------------------------------------------------------------------
// wrapping_layered_grid_store
// Layered 2D word store with wall or torus boundary, single-port memory.
// Steps: the remainder unit folds each coordinate, then fix-up, multiply and
// one memory access; busy stays high and no new beat is taken until it is done.
// Reset: a clearing pass zeroes the MAX_SIDE*MAX_SIDE*MAX_LAYERS words
// (65536 by default), one per cycle, with busy high; cfg writes still taken.
// The receiver cannot stall: out_valid is a one-cycle strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module wrapping_layered_grid_store #(
  parameter int MAX_SIDE   = wlgs_pkg::MAX_SIDE_DEF,
  parameter int MAX_LAYERS = wlgs_pkg::MAX_LAYERS_DEF,
  parameter int DATA_WIDTH = wlgs_pkg::DATA_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [wlgs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [wlgs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire                                   start,
  output logic                                  busy,
  input  wire                                   in_req_type,
  input  wire  signed [wlgs_pkg::COORD_W-1:0]   in_coord_x,
  input  wire  signed [wlgs_pkg::COORD_W-1:0]   in_coord_y,
  input  wire  signed [wlgs_pkg::LAYER_W-1:0]   in_layer,
  input  wire  signed [wlgs_pkg::VAL_W-1:0]     in_write_value,
  output logic                                  out_valid,
  output logic signed [wlgs_pkg::VAL_W-1:0]     out_read_value,
  output logic [wlgs_pkg::STATUS_W-1:0]         out_status
);

  import wlgs_pkg::*;

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE * MAX_LAYERS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int EXT_W  = $clog2(MAX_SIDE + 1);
  localparam int CRD_W  = $clog2(MAX_SIDE);
  localparam int LAY_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_MEM  = 3'd5;

  // restoring remainder over one chunk of magnitude bits
  function automatic logic [CRD_W-1:0] mod_chunk(input logic [CRD_W-1:0] rem_in,
                                                 input logic [MOD_STEP-1:0] bits,
                                                 input logic [EXT_W-1:0] s);
    logic [CRD_W:0]   t;
    logic [CRD_W-1:0] r;
    r = rem_in;
    for (int i = MOD_STEP - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= (CRD_W + 1)'(s)) begin
        t = t - (CRD_W + 1)'(s);
      end
      r = t[CRD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [EXT_W-1:0] extent(input logic [SIZE_W-1:0] r);
    logic [EXT_W-1:0] e;
    if (r == '0) begin
      e = EXT_W'(1);
    end else if (int'(r) > MAX_SIDE) begin
      e = EXT_W'(MAX_SIDE);
    end else begin
      e = EXT_W'(r);
    end
    return e;
  endfunction

  // configuration
  logic [SIZE_W-1:0] size_x_r, size_y_r;
  logic [LCNT_W-1:0] layer_count_r;
  logic              torus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r      <= SIZE_W'(128);
      size_y_r      <= SIZE_W'(128);
      layer_count_r <= LCNT_W'(1);
      torus_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_X:      size_x_r      <= cfg_wdata;
        CFG_SIZE_Y:      size_y_r      <= cfg_wdata;
        CFG_LAYER_COUNT: layer_count_r <= cfg_wdata[LCNT_W-1:0];
        CFG_TORUS:       torus_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // control
  logic [2:0]           state_r, state_nxt;
  logic [ADDR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_r, mod_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;

  // item payload
  logic                 wr_r;
  logic                 store_ok_r;
  rsel_t                rsel_r;
  logic [STATUS_W-1:0]  status_r;
  logic [EXT_W-1:0]     sx_r, sy_r;
  logic [LAY_W-1:0]     ly_r;
  logic                 xneg_r, yneg_r;
  logic [COORD_W-1:0]   xmag_r, ymag_r;
  logic [CRD_W-1:0]     xrem_r, yrem_r;
  logic [CRD_W-1:0]     wx_r, wy_r;
  logic [ADDR_W-1:0]    plane_r, xy_r, lofs_r;
  logic signed [DATA_WIDTH-1:0] wdata_r;

  // accept-time decode and negative-coordinate fix-up terms
  logic [EXT_W-1:0]     sx, sy;
  logic                 layer_bad, x_out, y_out, wall_out;
  logic [COORD_W-1:0]   xmag, ymag;
  logic [CRD_W:0]       xfix, yfix;

  assign accept = (state_r == S_IDLE) && start;
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    sx        = extent(size_x_r);
    sy        = extent(size_y_r);
    layer_bad = in_layer[LAYER_W-1] ||
                ((int'(layer_count_r) > MAX_LAYERS) ? (int'(in_layer) >= MAX_LAYERS)
                                                     : (int'(in_layer) >= int'(layer_count_r)));
    x_out     = in_coord_x[COORD_W-1] || (COORD_W'(in_coord_x) >= COORD_W'(sx));
    y_out     = in_coord_y[COORD_W-1] || (COORD_W'(in_coord_y) >= COORD_W'(sy));
    wall_out  = !torus_r && (x_out || y_out);
    xmag      = in_coord_x[COORD_W-1] ? COORD_W'(-in_coord_x) : COORD_W'(in_coord_x);
    ymag      = in_coord_y[COORD_W-1] ? COORD_W'(-in_coord_y) : COORD_W'(in_coord_y);
    xfix      = (CRD_W + 1)'(sx_r) - (CRD_W + 1)'(xrem_r);
    yfix      = (CRD_W + 1)'(sy_r) - (CRD_W + 1)'(yrem_r);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    mod_cnt_nxt   = mod_cnt_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mod_cnt_nxt = '0;
        if (start) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        mod_cnt_nxt = mod_cnt_r + 1'b1;
        if (mod_cnt_r == MOD_CNT_W'(MOD_CYC - 1)) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: state_nxt = S_MUL;
      S_MUL: state_nxt = S_MEM;
      S_MEM: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      mod_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_r       <= (in_req_type == REQ_WRITE);
      store_ok_r <= !layer_bad && !wall_out;
      sx_r       <= sx;
      sy_r       <= sy;
      ly_r       <= LAY_W'(in_layer[LCNT_W-1:0]);
      xneg_r     <= in_coord_x[COORD_W-1];
      yneg_r     <= in_coord_y[COORD_W-1];
      xmag_r     <= xmag;
      ymag_r     <= ymag;
      xrem_r     <= '0;
      yrem_r     <= '0;
      wdata_r    <= DATA_WIDTH'(in_write_value);
      if (layer_bad) begin
        status_r <= ST_BAD_LAYER;
        rsel_r   <= RSEL_ZERO;
      end else if (wall_out) begin
        status_r <= (in_req_type == REQ_WRITE) ? ST_BAD_WRITE : ST_OK;
        rsel_r   <= (in_req_type == REQ_WRITE) ? RSEL_ZERO : RSEL_ONES;
      end else begin
        status_r <= ST_OK;
        rsel_r   <= (in_req_type == REQ_WRITE) ? RSEL_ZERO : RSEL_MEM;
      end
    end
    if (state_r == S_MOD) begin
      xrem_r <= mod_chunk(xrem_r, xmag_r[COORD_W-1 -: MOD_STEP], sx_r);
      yrem_r <= mod_chunk(yrem_r, ymag_r[COORD_W-1 -: MOD_STEP], sy_r);
      xmag_r <= xmag_r << MOD_STEP;
      ymag_r <= ymag_r << MOD_STEP;
    end
    if (state_r == S_FIX) begin
      wx_r    <= (xneg_r && xrem_r != '0) ? xfix[CRD_W-1:0] : xrem_r;
      wy_r    <= (yneg_r && yrem_r != '0) ? yfix[CRD_W-1:0] : yrem_r;
      plane_r <= ADDR_W'(sx_r) * ADDR_W'(sy_r);
    end
    if (state_r == S_MUL) begin
      xy_r   <= ADDR_W'(wx_r) * ADDR_W'(sy_r) + ADDR_W'(wy_r);
      lofs_r <= ADDR_W'(ly_r) * plane_r;
    end
  end

  // grid memory
  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] mem_q_r;
  logic [ADDR_W-1:0]            mem_addr;
  logic                         mem_we;
  logic signed [DATA_WIDTH-1:0] mem_wd;

  always_comb begin
    if (state_r == S_CLR) begin
      mem_addr = clr_cnt_r;
      mem_we   = 1'b1;
      mem_wd   = '0;
    end else begin
      mem_addr = xy_r + lofs_r;
      mem_we   = (state_r == S_MEM) && wr_r && store_ok_r;
      mem_wd   = wdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q_r <= mem[mem_addr];
  end

  // result beat
  assign out_valid  = out_valid_r;
  assign out_status = status_r;

  always_comb begin
    unique case (rsel_r)
      RSEL_ONES: out_read_value = '1;
      RSEL_MEM:  out_read_value = VAL_W'(mem_q_r);
      default:   out_read_value = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> tb/wrapping_layered_grid_store_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// wrapping_layered_grid_store_tb
// Self-checking bench for the layered grid store. A local model of the store,
// its extents and its boundary mode predicts every beat's word and status.
// Directed beats cover defaults, wall edges, torus wrap and register clamps.
// Random phases then sweep grid settings with mixed reads and writes.
// ---------------------------------------------------------------------------

module wrapping_layered_grid_store_tb;
  import wlgs_pkg::*;

  localparam int STORE_WORDS = MAX_SIDE_DEF * MAX_SIDE_DEF * MAX_LAYERS_DEF;
  localparam logic [VAL_W-1:0] WALL_READ = '1;

  typedef struct packed {
    logic [VAL_W-1:0]    value;
    logic [STATUS_W-1:0] status;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic start;
  logic busy;
  logic in_req_type;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic signed [LAYER_W-1:0] in_layer;
  logic signed [VAL_W-1:0] in_write_value;
  logic out_valid;
  logic signed [VAL_W-1:0] out_read_value;
  logic [STATUS_W-1:0] out_status;

  // grid model and its register copy
  logic [VAL_W-1:0] grid_words [0:STORE_WORDS-1];
  logic [SIZE_W-1:0] reg_size_x;
  logic [SIZE_W-1:0] reg_size_y;
  logic [LCNT_W-1:0] reg_layers;
  logic reg_torus;

  answer_t pending_answers[$];
  int beats_sent;
  int beats_checked;
  int mismatches;
  int n_reads, n_writes, n_bad_layer, n_bad_write, n_outside_reads, n_settings;
  bit no_idle;

  wrapping_layered_grid_store dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y),
    .in_layer(in_layer),
    .in_write_value(in_write_value),
    .out_valid(out_valid),
    .out_read_value(out_read_value),
    .out_status(out_status)
  );

  always #2 clk = ~clk;

  function automatic int eff_extent(input logic [SIZE_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return int'(r);
  endfunction

  function automatic int eff_layers(input logic [LCNT_W-1:0] r);
    return (r > MAX_LAYERS_DEF) ? MAX_LAYERS_DEF : int'(r);
  endfunction

  function automatic int floor_mod(input int c, input int s);
    int r;
    r = c % s;
    if (r < 0) r += s;
    return r;
  endfunction

  function automatic answer_t predict_access(input logic req,
                                             input logic signed [COORD_W-1:0] cx,
                                             input logic signed [COORD_W-1:0] cy,
                                             input logic signed [LAYER_W-1:0] cl,
                                             input logic signed [VAL_W-1:0] wv);
    answer_t a;
    int x, y, ly, sx, sy, lc, addr;
    x = cx;
    y = cy;
    ly = cl;
    sx = eff_extent(reg_size_x);
    sy = eff_extent(reg_size_y);
    lc = eff_layers(reg_layers);
    a.value = '0;
    a.status = ST_OK;
    if (req == REQ_WRITE) n_writes++;
    else n_reads++;
    if (ly < 0 || ly >= lc) begin
      a.status = ST_BAD_LAYER;
      n_bad_layer++;
      return a;
    end
    if (!reg_torus) begin
      if (x < 0 || x >= sx || y < 0 || y >= sy) begin
        if (req == REQ_WRITE) begin
          a.status = ST_BAD_WRITE;
          n_bad_write++;
        end else begin
          a.value = WALL_READ;
          n_outside_reads++;
        end
        return a;
      end
    end else begin
      x = floor_mod(x, sx);
      y = floor_mod(y, sy);
    end
    addr = y + x * sy + ly * sx * sy;
    if (req == REQ_WRITE) grid_words[addr] = wv;
    else a.value = grid_words[addr];
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // accept beats and check results on the rising edge
  always @(posedge clk) begin
    answer_t want;
    answer_t fresh;
    if (out_valid === 1'b1) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with nothing pending", out_read_value, '0);
      end else begin
        want = pending_answers.pop_front();
        beats_checked++;
        if (out_read_value !== want.value)
          report_mismatch("read_value", out_read_value, want.value);
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
      end
    end
    if (rst_n && start && busy === 1'b0) begin
      fresh = predict_access(in_req_type, in_coord_x, in_coord_y,
                             in_layer, in_write_value);
      pending_answers = {pending_answers, fresh};
      beats_sent++;
    end
  end

  task automatic send_beat(input logic req, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [LAYER_W-1:0] ly,
                           input logic signed [VAL_W-1:0] v);
    int gap;
    int seen;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    seen = beats_sent;
    in_req_type <= req;
    in_coord_x <= x;
    in_coord_y <= y;
    in_layer <= ly;
    in_write_value <= v;
    start <= 1'b1;
    do @(negedge clk); while (beats_sent == seen);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending_answers.size() != 0 || busy !== 1'b0);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy,
                            input logic [CFG_DATA_W-1:0] lc, input logic [CFG_DATA_W-1:0] tor);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SIZE_X;
    cfg_wdata <= sx;
    @(negedge clk);
    cfg_index <= CFG_SIZE_Y;
    cfg_wdata <= sy;
    @(negedge clk);
    cfg_index <= CFG_LAYER_COUNT;
    cfg_wdata <= lc;
    @(negedge clk);
    cfg_index <= CFG_TORUS;
    cfg_wdata <= tor;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_size_x = sx;
    reg_size_y = sy;
    reg_layers = lc[LCNT_W-1:0];
    reg_torus = tor[0];
    n_settings++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd128;
      3: return 8'($urandom_range(129, 255));
      8, 9: return 8'($urandom_range(1, 128));
      default: return 8'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_layers();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'($urandom_range(5, 255));
      default: return 8'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(input int s);
    case ($urandom_range(0, 19))
      0: return -16'sd1;
      1: return 16'(s);
      2: return 16'(s - 1);
      3, 4, 5, 6: return 16'($urandom);
      default: return 16'($urandom_range(0, s - 1));
    endcase
  endfunction

  task automatic random_beat();
    int sx, sy, lc;
    logic signed [LAYER_W-1:0] ly;
    logic signed [VAL_W-1:0] v;
    sx = eff_extent(reg_size_x);
    sy = eff_extent(reg_size_y);
    lc = eff_layers(reg_layers);
    if (lc > 0 && $urandom_range(0, 9) != 0) ly = 4'($urandom_range(0, lc - 1));
    else ly = 4'($urandom);
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = '1;
      default: v = $urandom;
    endcase
    send_beat($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
              pick_coord(sx), pick_coord(sy), ly, v);
  endtask

  task automatic test_default_grid();
    wait_idle();
    send_beat(REQ_READ, 16'sd0, 16'sd0, 4'sd0, 32'sd0);
    send_beat(REQ_WRITE, 16'sd127, 16'sd127, 4'sd0, 32'h7fff_ffff);
    send_beat(REQ_READ, 16'sd127, 16'sd127, 4'sd0, 32'sd0);
    send_beat(REQ_READ, 16'sd128, 16'sd0, 4'sd0, 32'sd0);
    send_beat(REQ_WRITE, -16'sd1, 16'sd5, 4'sd0, 32'sd99);
    send_beat(REQ_READ, 16'sd0, 16'sd0, 4'sd1, 32'sd0);
    send_beat(REQ_WRITE, 16'sd0, 16'sd0, -4'sd8, 32'sd5);
  endtask

  task automatic test_wall_edges();
    set_config(8'd5, 8'd3, 8'd2, 8'd0);
    send_beat(REQ_WRITE, 16'sd4, 16'sd2, 4'sd1, 32'h8000_0000);
    send_beat(REQ_READ, 16'sd4, 16'sd2, 4'sd1, 32'sd0);
    send_beat(REQ_READ, 16'sd4, 16'sd3, 4'sd1, 32'sd0);
    send_beat(REQ_WRITE, 16'sd5, 16'sd0, 4'sd0, 32'sd1);
    send_beat(REQ_READ, 16'h8000, 16'h7fff, 4'sd0, 32'sd0);
    send_beat(REQ_WRITE, 16'sd0, 16'sd0, 4'sd7, 32'sd1);
  endtask

  task automatic test_torus_wrap();
    set_config(8'd7, 8'd5, 8'd3, 8'd1);
    send_beat(REQ_WRITE, -16'sd1, -16'sd1, 4'sd2, 32'hffff_ffff);
    send_beat(REQ_READ, 16'sd6, 16'sd4, 4'sd2, 32'sd0);
    send_beat(REQ_WRITE, 16'h7fff, 16'h8000, 4'sd0, 32'h1234_5678);
    send_beat(REQ_READ, 16'sd0, 16'sd2, 4'sd0, 32'sd0);
    send_beat(REQ_READ, 16'sd0, 16'sd0, 4'sd3, 32'sd0);
  endtask

  task automatic test_register_clamps();
    set_config(8'd0, 8'd0, 8'd0, 8'd0);
    send_beat(REQ_READ, 16'sd0, 16'sd0, 4'sd0, 32'sd0);
    set_config(8'd255, 8'd255, 8'hff, 8'd1);
    send_beat(REQ_WRITE, -16'sd1, -16'sd1, 4'sd3, 32'h5a5a_a5a5);
    send_beat(REQ_READ, 16'sd127, 16'sd127, 4'sd3, 32'sd0);
    set_config(8'd1, 8'd1, 8'd1, 8'd0);
    send_beat(REQ_READ, 16'sd1, 16'sd0, 4'sd0, 32'sd0);
  endtask

  task automatic test_random_traffic();
    int ph, k;
    for (ph = 0; ph < 12; ph++) begin
      if (ph == 0) set_config(8'd128, 8'd128, 8'd4, 8'd1);
      else if (ph == 1) set_config(8'd1, 8'd1, 8'd1, 8'd0);
      else set_config(pick_size(), pick_size(), pick_layers(), 8'($urandom_range(0, 1)));
      no_idle = (ph % 4 == 2);
      for (k = 0; k < 96; k++) begin
        if (k == 48 && ph % 3 == 0) wait_idle();
        random_beat();
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int w;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SIZE_X;
    cfg_wdata = '0;
    start = 1'b0;
    in_req_type = REQ_READ;
    in_coord_x = '0;
    in_coord_y = '0;
    in_layer = '0;
    in_write_value = '0;
    for (w = 0; w < STORE_WORDS; w++) grid_words[w] = '0;
    reg_size_x = 8'd128;
    reg_size_y = 8'd128;
    reg_layers = 3'd1;
    reg_torus = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_default_grid();
    test_wall_edges();
    test_torus_wrap();
    test_register_clamps();
    test_random_traffic();

    wait_idle();
    repeat (12) @(negedge clk);
    $display("Covered %0d beats (%0d reads, %0d writes) over %0d grid settings",
             beats_sent, n_reads, n_writes, n_settings + 1);
    $display("Outcomes: %0d layer errors, %0d rejected wall writes, %0d outside reads",
             n_bad_layer, n_bad_write, n_outside_reads);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
